/* rtl/wl53_pkg.sv */
package wl53_pkg;

    // Sample and coefficient word: signed Q16.16.
    localparam int WORD_W = 32;
    // Width of the length register.
    localparam int CFG_W = 3;
    // Shortest and longest block, as log2 of the sample count.
    localparam int LOG2_LO = 2;
    localparam int LOG2_HI = 6;
    localparam int LOG2_RESET = 6;
    localparam int MAX_LENGTH_DEFAULT = 64;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CFG_W-1:0] t_log2;

    // Adds two words and clamps the result to the signed 32-bit range.
    function automatic t_word f_sat_add(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return s[WORD_W-1:0];
    endfunction

    // Floor of -x / 2^sh, which is the truncated product with a negative
    // power-of-two tap.
    function automatic t_word f_neg_shr(input t_word x, input int sh);
        logic signed [WORD_W:0] n;
        n = -{x[WORD_W-1], x};
        n = n >>> sh;
        return n[WORD_W-1:0];
    endfunction

    // Floor of x / 4.
    function automatic t_word f_quarter(input t_word x);
        return x >>> 2;
    endfunction

    // Floor of 3x / 4.
    function automatic t_word f_three_quarter(input t_word x);
        logic signed [WORD_W+1:0] t;
        t = {{2{x[WORD_W-1]}}, x} + {x[WORD_W-1], x, 1'b0};
        t = t >>> 2;
        return t[WORD_W-1:0];
    endfunction

endpackage

/* rtl/wl53_if.sv */
interface wl53_smp_if import wl53_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wl53_coef_if import wl53_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word coefficient;
    logic  last;

    modport source (output valid, output coefficient, output last, input ready);
    modport sink (input valid, input coefficient, input last, output ready);
endinterface

interface wl53_cfg_if import wl53_pkg::*; ();
    logic  valid;
    logic  ready;
    t_log2 log2_length;

    modport source (output valid, output log2_length, input ready);
    modport sink (input valid, input log2_length, output ready);
endinterface

/* rtl/wavelet53_forward_multilevel_unit.sv */
// Multi-level LeGall 5/3 forward wavelet transform over blocks of N = 2^log2_length
// signed Q16.16 samples (log2_length clamped to 2..6 and to what MAX_LENGTH holds),
// with circular wrap at the band borders. Samples arrive one beat per cycle into the
// sample memory while the block is loading and no length write is offered; when the
// N-th beat is taken the block stops accepting samples and runs the levels. Each
// level of length L streams the band out of the sample memory once, waits for the
// filter pipeline to drain, and writes lowpass values back into the sample memory
// and highpass values into the work memory. The N coefficients are then sent in
// Mallat order at up to one beat per cycle as the output buffer has room, with last
// set on the final one. The next block's samples are taken as soon as the last
// coefficient has entered the two-entry output buffer, which drains independently.
// A write of log2_length is taken only while the block is loading samples and
// discards any samples already collected for the current block.
module wavelet53_forward_multilevel_unit import wl53_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
    input logic        i_clk,
    input logic        i_rst_n,
    wl53_cfg_if.sink   i_cfg,
    wl53_smp_if.sink   i_smp,
    wl53_coef_if.source o_coef
);

    localparam int LOG2_FLOOR = $clog2(MAX_LENGTH + 1) - 1;
    localparam int CAP_LOG2 = (LOG2_FLOOR < LOG2_HI) ? LOG2_FLOOR : LOG2_HI;
    localparam int DEPTH = 1 << CAP_LOG2;
    localparam int AW = CAP_LOG2;
    localparam int CW = AW + 1;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_XFORM = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]    r_state, n_state;
    t_log2         r_log2;
    t_log2         eff_log2;
    logic [CW-1:0] blk_len;
    logic [AW-1:0] r_load_cnt;
    logic [CW-1:0] r_blk_len, r_len, r_k, r_e;
    logic          smp_acc, cfg_acc;

    // The two memories: samples and lowpass bands, and highpass bands.
    t_word         smp_mem [DEPTH];
    t_word         wrk_mem [DEPTH];
    t_word         r_smp_q, r_wrk_q;
    logic [AW-1:0] smp_raddr;

    // Read stage and filter window.
    logic          r_d1_vld;
    logic [CW-1:0] r_d1_k;
    t_word         r_wrap [3];
    t_word         r_win [4];
    t_word         x_new;
    logic [CW-1:0] wrap_off;
    logic          pair_fire;
    logic [AW-1:0] pair_idx;

    // Filter pipeline.
    logic          r_p_vld, r_a_vld, r_b_vld, r_c_vld;
    logic [AW-1:0] r_p_idx, r_a_idx, r_b_idx, r_c_idx;
    t_word         r_p_lo [5];
    t_word         r_p_hi [3];
    t_word         r_a_lo, r_a_hi, r_a_h2;
    t_word         r_a_lt [3];
    t_word         r_b_lo, r_b_hi;
    t_word         r_b_lt [2];
    t_word         r_c_lo, r_c_hi, r_c_t4;
    logic          pipe_busy;
    logic [AW-1:0] hi_waddr;

    // Emit path and output buffer.
    logic          em_issue, em_room;
    logic          r_em_pend, r_em_low, r_em_last;
    t_word         r_ob_data [2];
    logic          r_ob_last [2];
    logic          r_ob_wp, r_ob_rp;
    logic [1:0]    r_ob_cnt;
    logic          ob_push, ob_pop;

    // Effective block length.
    always_comb begin
        if (r_log2 < CFG_W'(LOG2_LO)) begin
            eff_log2 = CFG_W'(LOG2_LO);
        end else if (r_log2 > CFG_W'(CAP_LOG2)) begin
            eff_log2 = CFG_W'(CAP_LOG2);
        end else begin
            eff_log2 = r_log2;
        end
        blk_len = CW'(1) << eff_log2;
    end

    assign i_cfg.ready = (r_state == ST_LOAD);
    assign i_smp.ready = (r_state == ST_LOAD) && !i_cfg.valid;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign smp_acc     = i_smp.valid && i_smp.ready;

    assign pipe_busy = r_d1_vld || r_p_vld || r_a_vld || r_b_vld || r_c_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (smp_acc && (r_load_cnt == AW'(blk_len - CW'(1)))) begin
                    n_state = ST_XFORM;
                end
            end
            ST_XFORM: begin
                if (r_k == r_len + CW'(2)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = (r_len == CW'(4)) ? ST_EMIT : ST_XFORM;
                end
            end
            ST_EMIT: begin
                if ((r_e == r_blk_len) && !r_em_pend) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_log2     <= CFG_W'(LOG2_RESET);
            r_load_cnt <= '0;
            r_blk_len  <= '0;
            r_len      <= '0;
            r_k        <= '0;
            r_e        <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_log2     <= i_cfg.log2_length;
                r_load_cnt <= '0;
            end else if (smp_acc) begin
                if (n_state == ST_XFORM) begin
                    r_load_cnt <= '0;
                    r_blk_len  <= blk_len;
                    r_len      <= blk_len;
                    r_k        <= '0;
                end else begin
                    r_load_cnt <= r_load_cnt + AW'(1);
                end
            end
            if (r_state == ST_XFORM) begin
                r_k <= r_k + CW'(1);
            end
            if ((r_state == ST_DRAIN) && !pipe_busy) begin
                if (r_len == CW'(4)) begin
                    r_e <= '0;
                end else begin
                    r_len <= r_len >> 1;
                    r_k   <= '0;
                end
            end
            if (em_issue) begin
                r_e <= r_e + CW'(1);
            end
        end
    end

    // Memory access. Within a level every lowpass write lands on an address the
    // read stream has already passed, and the wrap-around reads come from r_wrap,
    // so reads and write-backs of one level never touch the same entry out of turn.
    assign smp_raddr = (r_state == ST_EMIT) ? r_e[AW-1:0] : r_k[AW-1:0];
    assign hi_waddr  = AW'((r_len >> 1) + CW'(r_c_idx));

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LOAD) && smp_acc) begin
            smp_mem[r_load_cnt] <= i_smp.sample;
        end else if (r_c_vld) begin
            smp_mem[r_c_idx] <= f_sat_add(r_c_lo, r_c_t4);
        end
        if (r_c_vld) begin
            wrk_mem[hi_waddr] <= r_c_hi;
        end
        r_smp_q <= smp_mem[smp_raddr];
        r_wrk_q <= wrk_mem[r_e[AW-1:0]];
    end

    // Read stage: build the value stream x[0..L+2] with the first three samples
    // of the band replayed at the end for the circular wrap.
    assign wrap_off  = r_d1_k - r_len;
    assign x_new     = (r_d1_k < r_len) ? r_smp_q : r_wrap[wrap_off[1:0]];
    assign pair_fire = r_d1_vld && !r_d1_k[0] && (r_d1_k >= CW'(4));
    assign pair_idx  = AW'((r_d1_k >> 1) - CW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
        end else begin
            r_d1_vld <= (r_state == ST_XFORM);
            r_p_vld  <= pair_fire;
            r_a_vld  <= r_p_vld;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_k <= r_k;
        if (r_d1_vld) begin
            if (r_d1_k < CW'(3)) begin
                r_wrap[r_d1_k[1:0]] <= r_smp_q;
            end
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= x_new;
        end

        // Tap products: all taps are signed powers of two or three quarters.
        r_p_idx   <= pair_idx;
        r_p_lo[0] <= f_neg_shr(r_win[0], 3);
        r_p_lo[1] <= f_quarter(r_win[1]);
        r_p_lo[2] <= f_three_quarter(r_win[2]);
        r_p_lo[3] <= f_quarter(r_win[3]);
        r_p_lo[4] <= f_neg_shr(x_new, 3);
        r_p_hi[0] <= f_neg_shr(r_win[0], 1);
        r_p_hi[1] <= r_win[1];
        r_p_hi[2] <= f_neg_shr(r_win[2], 1);

        // Saturating accumulation, left to right, one addition per stage.
        r_a_idx   <= r_p_idx;
        r_a_lo    <= f_sat_add(r_p_lo[0], r_p_lo[1]);
        r_a_hi    <= f_sat_add(r_p_hi[0], r_p_hi[1]);
        r_a_h2    <= r_p_hi[2];
        r_a_lt[0] <= r_p_lo[2];
        r_a_lt[1] <= r_p_lo[3];
        r_a_lt[2] <= r_p_lo[4];

        r_b_idx   <= r_a_idx;
        r_b_lo    <= f_sat_add(r_a_lo, r_a_lt[0]);
        r_b_hi    <= f_sat_add(r_a_hi, r_a_h2);
        r_b_lt[0] <= r_a_lt[1];
        r_b_lt[1] <= r_a_lt[2];

        r_c_idx <= r_b_idx;
        r_c_lo  <= f_sat_add(r_b_lo, r_b_lt[0]);
        r_c_hi  <= r_b_hi;
        r_c_t4  <= r_b_lt[1];
    end

    // Emit: the final lowpass pair sits in the sample memory, the highpass bands
    // in the work memory. A read is issued only when the buffer is sure to have
    // room for it in the next cycle, when the read data is pushed.
    assign ob_push  = r_em_pend;
    assign ob_pop   = o_coef.valid && o_coef.ready;
    assign em_room  = (({1'b0, r_ob_cnt} + {2'b00, r_em_pend}) - {2'b00, ob_pop}) <= 3'd1;
    assign em_issue = (r_state == ST_EMIT) && (r_e < r_blk_len) && em_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_pend <= 1'b0;
            r_ob_wp   <= 1'b0;
            r_ob_rp   <= 1'b0;
            r_ob_cnt  <= '0;
        end else begin
            r_em_pend <= em_issue;
            if (ob_push) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + {1'b0, ob_push} - {1'b0, ob_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_em_low  <= (r_e < CW'(2));
        r_em_last <= (r_e == r_blk_len - CW'(1));
        if (ob_push) begin
            r_ob_data[r_ob_wp] <= r_em_low ? r_smp_q : r_wrk_q;
            r_ob_last[r_ob_wp] <= r_em_last;
        end
    end

    assign o_coef.valid       = (r_ob_cnt != 2'd0);
    assign o_coef.coefficient = r_ob_data[r_ob_rp];
    assign o_coef.last        = r_ob_last[r_ob_rp];

    // Write-backs happen only while a level is running or draining.
    a_wb_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_state == ST_XFORM || r_state == ST_DRAIN))
        else $error("filter write-back outside a transform level");

    // A level may only be left once every write-back of it has landed.
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && n_state != ST_DRAIN) |-> !pipe_busy)
        else $error("level left with filter results still in flight");

    // The output buffer never takes a beat it has no room for.
    a_ob_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ob_push && r_ob_cnt == 2'd2) |-> ob_pop)
        else $error("output buffer overflow");

    // Emit reads are issued only in the emit phase.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_pend |-> $past(r_state == ST_EMIT))
        else $error("coefficient read outside the emit phase");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import wl53_pkg::*;

    // Bench timing and pacing.
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    // Quiet cycles, with nothing owed, before a length write is offered.
    localparam int SETTLE_CYCLES = 20;
    // Cycles allowed after the last coefficient before the verdict.
    localparam int DRAIN_CYCLES = 40;
    // The one long stretch in which the coefficient side refuses beats.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any beat on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    // Once this few jobs are left, neither side idles any more.
    localparam int TAIL_JOBS = 40;
    // Rough number of samples in the whole run.
    localparam int SAMPLE_TARGET = 330;

    // Filter taps in Q16.16.
    localparam int TAP_NEG_EIGHTH = -8192;
    localparam int TAP_QUARTER = 16384;
    localparam int TAP_THREE_QUARTERS = 49152;
    localparam int TAP_NEG_HALF = -32768;
    localparam int TAP_ONE = 65536;

    localparam longint WORD_MAX = 2147483647;
    localparam longint WORD_MIN = -longint'(2147483647) - 1;
    localparam t_word SAMPLE_MAX = 32'sh7fff_ffff;
    localparam t_word SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [0:0] {JOB_SAMPLE, JOB_LENGTH} t_job_kind;

    // One entry of the stimulus script: either a sample beat or a write of
    // the length register.
    typedef struct {
        t_job_kind kind;
        t_word     sample;
        t_log2     log2_length;
    } t_job;

    typedef struct {
        t_word coefficient;
        logic  last;
    } t_coef_beat;

    logic i_clk;
    logic i_rst_n;

    wl53_cfg_if  cfg_bus ();
    wl53_smp_if  smp_bus ();
    wl53_coef_if coef_bus ();

    wavelet53_forward_multilevel_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_smp   (smp_bus),
        .o_coef  (coef_bus)
    );

    // Stimulus script, filled at time zero and consumed by the driver.
    t_job job_q[$];
    int   queued_samples = 0;
    // Accepted-sample count at which the long coefficient hold-off begins.
    int   hold_at = 0;

    // Driver state.
    int   gap_left;
    int   settle_left;
    logic idle_ok;

    // Receiver state.
    int   stall_left;
    logic hold_done;

    // Shadow of the block: length register, sample memory and load count,
    // plus the coefficients that are still owed.
    t_log2      pred_log2;
    int         pred_fill;
    t_word      pred_buf [MAX_LENGTH_DEFAULT];
    t_word      coef_work [MAX_LENGTH_DEFAULT];
    t_coef_beat coef_expected_q[$];
    int         coefs_seen;

    // Counters that other processes read; these are only ever updated with
    // nonblocking assignments so that a reader at the clock edge always
    // sees the value from before the edge.
    int coefs_owed;
    int samples_taken;

    int mismatches = 0;
    int quiet_cycles;

    // Each mismatch is one line, and each is counted.
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Block length for a register value: clamped to 4..64 samples, and then
    // lowered until it fits in the sample memory.
    function automatic int block_length(input t_log2 l2);
        int l;
        l = int'(l2);
        if (l < LOG2_LO) l = LOG2_LO;
        if (l > LOG2_HI) l = LOG2_HI;
        while (l > LOG2_LO && (1 << l) > MAX_LENGTH_DEFAULT) l--;
        return 1 << l;
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Q16.16 product with the fraction below 2^-16 dropped towards minus
    // infinity.
    function automatic longint scaled_product(input t_word x, input int tap);
        longint p;
        p = longint'(x) * longint'(tap);
        return p >>> 16;
    endfunction

    function automatic int filter_tap(input bit lowpass, input int k);
        if (lowpass) begin
            case (k)
                0, 4: return TAP_NEG_EIGHTH;
                2: return TAP_THREE_QUARTERS;
                default: return TAP_QUARTER;
            endcase
        end
        return (k == 1) ? TAP_ONE : TAP_NEG_HALF;
    endfunction

    // One output of a level: taps summed left to right over a band of
    // length len with circular wrap, saturating after every addition.
    function automatic t_word band_filter(input int len, input int base, input bit lowpass);
        longint acc;
        int     k;
        acc = 0;
        for (k = 0; k < (lowpass ? 5 : 3); k++) begin
            acc = clamp_word(acc + scaled_product(pred_buf[(base + k) & (len - 1)],
                                                  filter_tap(lowpass, k)));
        end
        return t_word'(acc);
    endfunction

    // Runs every level over the collected block and queues the coefficients
    // in Mallat order. Each level leaves its highpass half in the upper part
    // of the work array and feeds its lowpass half to the next level, so at
    // the end the array already holds the final lowpass pair followed by the
    // highpass bands from coarsest to finest.
    function automatic void transform_block(input int n);
        int         len;
        int         half;
        int         i;
        t_coef_beat beat;
        len = n;
        while (len > 2) begin
            half = len / 2;
            for (i = 0; i < half; i++) begin
                coef_work[i] = band_filter(len, 2 * i, 1'b1);
                coef_work[half + i] = band_filter(len, 2 * i, 1'b0);
            end
            for (i = 0; i < half; i++) begin
                pred_buf[i] = coef_work[i];
            end
            len = half;
        end
        for (i = 0; i < n; i++) begin
            beat.coefficient = coef_work[i];
            beat.last = (i == n - 1);
            coef_expected_q.push_back(beat);
        end
    endfunction

    function automatic void take_sample(input t_word s);
        int n;
        n = block_length(pred_log2);
        if (pred_fill >= n) pred_fill = 0;
        pred_buf[pred_fill] = s;
        pred_fill++;
        if (pred_fill == n) begin
            pred_fill = 0;
            transform_block(n);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus script
    // ---------------------------------------------------------------------

    task automatic add_sample(input t_word s);
        t_job j;
        j.kind = JOB_SAMPLE;
        j.sample = s;
        j.log2_length = '0;
        job_q.push_back(j);
        queued_samples++;
    endtask

    task automatic add_length(input t_log2 v);
        t_job j;
        j.kind = JOB_LENGTH;
        j.sample = '0;
        j.log2_length = v;
        job_q.push_back(j);
    endtask

    // A mix of full-range words, small values, the extremes and values near
    // them, so that saturation is hit regularly but not always.
    function automatic t_word random_sample();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            1: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: return SAMPLE_MAX - t_word'($urandom_range(0, 32'h00ff_ffff));
            3: return SAMPLE_MIN + t_word'($urandom_range(0, 32'h00ff_ffff));
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic add_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            add_sample(random_sample());
        end
    endtask

    // ---------------------------------------------------------------------
    // Clock, reset and the run itself
    // ---------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        int   v;
        int   blocks;
        int   k;
        t_log2 len_sel;

        // Every input is at a known level before the first edge.
        i_rst_n = 1'b0;
        smp_bus.valid = 1'b0;
        smp_bus.sample = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.log2_length = '0;
        coef_bus.ready = 1'b0;

        // Directed part. The shortest block first, with the word extremes,
        // then alternating extremes so that the highpass sums saturate.
        add_length(t_log2'(2));
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);
        add_sample('0);
        add_sample('1);
        add_sample(SAMPLE_MIN);
        add_sample(SAMPLE_MAX);
        add_sample(SAMPLE_MIN);
        add_sample(SAMPLE_MAX);
        // Register values below the shortest length behave as the shortest.
        add_length(t_log2'(0));
        repeat (4) add_sample(SAMPLE_MAX);
        add_length(t_log2'(1));
        repeat (4) add_sample(SAMPLE_MIN);
        // A length write in the middle of a load throws the partial block
        // away; only the four samples after it form a block.
        add_length(t_log2'(3));
        add_sample(32'sh0000_0001);
        add_sample('1);
        add_sample(32'sh0001_0000);
        add_length(t_log2'(2));
        add_sample(32'sh5555_5555);
        add_sample(32'shaaaa_aaaa);
        add_sample(32'sh0000_0001);
        add_sample(32'sh0001_0000);

        // Random part. Register value 7 acts as the longest block. Two such
        // blocks run back to back, and the coefficient side is held off as
        // the first one completes, so the second fills the block up and its
        // sample input stalls.
        add_length(t_log2'(7));
        hold_at = queued_samples + 64;
        add_random(128);
        add_length(t_log2'(6));
        add_random(64);
        add_length(t_log2'(5));
        add_random(64);
        add_random(10);
        add_length(t_log2'(4));
        add_random(32);
        // The rest in short blocks mostly, some left unfinished on purpose.
        while (queued_samples + 8 < SAMPLE_TARGET) begin
            v = $urandom_range(0, 9);
            if (v < 6) len_sel = t_log2'($urandom_range(0, 3));
            else if (v < 9) len_sel = t_log2'(4);
            else len_sel = t_log2'($urandom_range(5, 7));
            add_length(len_sel);
            blocks = $urandom_range(1, 3);
            for (k = 0; k < blocks; k++) begin
                add_random(block_length(len_sel));
            end
            if ($urandom_range(0, 3) == 0) begin
                add_random($urandom_range(1, block_length(len_sel) - 1));
            end
        end
        // End on complete blocks of the shortest length.
        add_length(t_log2'(2));
        add_random(8);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every job has been taken and every coefficient has
        // come back, then give the block time to show any stray output.
        @(posedge i_clk);
        while (job_q.size() != 0 || smp_bus.valid || cfg_bus.valid || coefs_owed != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (coef_expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d coefficients never arrived",
                                      coef_expected_q.size()));
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Driver: samples and length writes, from the script, one at a time.
    // A length write waits until the block has nothing left to send and has
    // been quiet for a while, which is also where the sender pauses until
    // every owed coefficient has come.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin : drive
        logic smp_v;
        logic cfg_v;
        t_job job;
        if (!i_rst_n) begin
            smp_bus.valid <= 1'b0;
            smp_bus.sample <= '0;
            cfg_bus.valid <= 1'b0;
            cfg_bus.log2_length <= '0;
            gap_left <= 0;
            settle_left <= SETTLE_CYCLES;
            idle_ok <= 1'b0;
        end else begin
            // A beat that is offered and not yet taken stays on the bus.
            smp_v = smp_bus.valid && !smp_bus.ready;
            cfg_v = cfg_bus.valid && !cfg_bus.ready;
            if (!smp_v && !cfg_v) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (job_q.size() > 0) begin
                    if (job_q[0].kind == JOB_SAMPLE) begin
                        if (idle_ok && $urandom_range(0, 4) == 0) begin
                            // A random gap, this cycle included.
                            gap_left <= $urandom_range(0, 8);
                        end else begin
                            job = job_q.pop_front();
                            smp_bus.sample <= job.sample;
                            smp_v = 1'b1;
                        end
                    end else if (coefs_owed != 0) begin
                        settle_left <= SETTLE_CYCLES;
                    end else if (settle_left > 0) begin
                        settle_left <= settle_left - 1;
                    end else begin
                        job = job_q.pop_front();
                        cfg_bus.log2_length <= job.log2_length;
                        cfg_v = 1'b1;
                        settle_left <= SETTLE_CYCLES;
                    end
                end
            end
            smp_bus.valid <= smp_v;
            cfg_bus.valid <= cfg_v;
            // Idling comes and goes in stretches, and stops near the end.
            idle_ok <= (job_q.size() > TAIL_JOBS) && (((samples_taken / 48) % 3) != 2);
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: coefficient ready, with random stalls and one long hold-off.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin : receive
        if (!i_rst_n) begin
            coef_bus.ready <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && samples_taken >= hold_at) begin
            hold_done <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            coef_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            coef_bus.ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 8);
            coef_bus.ready <= 1'b0;
        end else begin
            coef_bus.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each coefficient beat against the oldest owed one and
    // feeds accepted length writes and samples to the predictor.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin : watch
        t_coef_beat want;
        if (!i_rst_n) begin
            pred_log2 = t_log2'(LOG2_RESET);
            pred_fill = 0;
            coefs_seen = 0;
            coef_expected_q.delete();
            coefs_owed <= 0;
            samples_taken <= 0;
        end else begin
            if (coef_bus.valid && coef_bus.ready) begin
                if (coef_expected_q.size() == 0) begin
                    report_mismatch($sformatf("coefficient beat %0d (%h) with none owed",
                                              coefs_seen, coef_bus.coefficient));
                end else begin
                    want = coef_expected_q.pop_front();
                    if (coef_bus.coefficient !== want.coefficient) begin
                        report_mismatch($sformatf("beat %0d coefficient %h, predicted %h",
                                                  coefs_seen, coef_bus.coefficient,
                                                  want.coefficient));
                    end
                    if (coef_bus.last !== want.last) begin
                        report_mismatch($sformatf("beat %0d last %b, predicted %b",
                                                  coefs_seen, coef_bus.last, want.last));
                    end
                end
                coefs_seen++;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                pred_log2 = cfg_bus.log2_length;
                pred_fill = 0;
            end
            if (smp_bus.valid && smp_bus.ready) begin
                take_sample(smp_bus.sample);
                samples_taken <= samples_taken + 1;
            end
            coefs_owed <= coef_expected_q.size();
        end
    end

    // Watchdog: a stretch with no beat on any channel that lasts too long
    // means the block has hung.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (smp_bus.valid && smp_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                || (coef_bus.valid && coef_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
